// File: sv/rtcas_pkg.sv
`default_nettype none

package rtcas_pkg;

    // request codes
    localparam logic [2:0] REQ_TICK  = 3'd0;
    localparam logic [2:0] REQ_SET   = 3'd1;
    localparam logic [2:0] REQ_ADD   = 3'd2;
    localparam logic [2:0] REQ_CLEAR = 3'd3;
    localparam logic [2:0] REQ_READ  = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    // rollover limits and register reset
    localparam logic [5:0] SEC_LIMIT  = 6'd60;
    localparam logic [5:0] MIN_LIMIT  = 6'd60;
    localparam logic [4:0] HOUR_LIMIT = 5'd24;
    localparam logic [7:0] RESET_TPS  = 8'd30;

    typedef struct packed {
        logic [2:0] req_type;
        logic [4:0] set_hours;
        logic [5:0] set_minutes;
        logic [5:0] set_seconds;
        logic [1:0] slot_index;
    } req_t;

    typedef struct packed {
        logic [4:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
        logic       alarm_active;
        logic [1:0] status;
        logic [1:0] slot_used;
        logic       slot_valid;
        logic [4:0] slot_hours;
        logic [5:0] slot_minutes;
    } rsp_t;

    // slot table write command
    typedef struct packed {
        logic       wr_en;
        logic       wr_set;
        logic [4:0] hour;
        logic [5:0] minute;
    } tbl_cmd_t;

    // slot table status
    typedef struct packed {
        logic       free_found;
        logic       rd_valid;
        logic [4:0] rd_hour;
        logic [5:0] rd_minute;
        logic       match;
    } tbl_stat_t;

endpackage

`default_nettype wire

// File: sv/rtcas_alarm_table.sv
`default_nettype none

module rtcas_alarm_table #(
    parameter int ALARM_SLOTS = 4,
    localparam int SLOT_W = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire rtcas_pkg::tbl_cmd_t  cmd,
    input  wire logic [SLOT_W-1:0]    wr_slot,
    input  wire logic [SLOT_W-1:0]    rd_slot,
    input  wire logic [4:0]           cmp_hour,
    input  wire logic [5:0]           cmp_minute,
    output rtcas_pkg::tbl_stat_t      stat,
    output logic [SLOT_W-1:0]         free_slot
);

    logic [ALARM_SLOTS-1:0] valid_reg;
    logic [ALARM_SLOTS-1:0] valid_next;
    logic [4:0]             hour_reg   [ALARM_SLOTS];
    logic [4:0]             hour_next  [ALARM_SLOTS];
    logic [5:0]             minute_reg [ALARM_SLOTS];
    logic [5:0]             minute_next[ALARM_SLOTS];
    logic                   free_found;
    logic                   hit;

    // lowest free slot, one check per slot
    always_comb
    begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int k = ALARM_SLOTS - 1; k >= 0; k--)
        begin
            if (!valid_reg[k])
            begin
                free_found = 1'b1;
                free_slot  = SLOT_W'(k);
            end
        end
    end

    always_comb
    begin
        valid_next  = valid_reg;
        hour_next   = hour_reg;
        minute_next = minute_reg;
        if (cmd.wr_en)
        begin
            valid_next[wr_slot]  = cmd.wr_set;
            hour_next[wr_slot]   = cmd.hour;
            minute_next[wr_slot] = cmd.minute;
        end
    end

    // match against the table as it stands after this request
    always_comb
    begin
        hit = 1'b0;
        for (int k = 0; k < ALARM_SLOTS; k++)
        begin
            if (valid_next[k] && hour_next[k] == cmp_hour && minute_next[k] == cmp_minute)
            begin
                hit = 1'b1;
            end
        end
    end

    assign stat = {free_found, valid_reg[rd_slot], hour_reg[rd_slot], minute_reg[rd_slot],
                   hit};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hour_reg   <= hour_next;
        minute_reg <= minute_next;
    end

endmodule

`default_nettype wire

// File: sv/rtc_with_alarm_slots_top.sv
// a request is taken into the input register, then its result is loaded into the result
// register when that register is empty or being drained
// throughput: 1 transaction per cycle unless a response is held, set by the input
// and result registers; each request is resolved in one pass of logic between them
// reset: time, prescaler and alarm slot table cleared, ticks_per_second back to 30
`default_nettype none

module rtc_with_alarm_slots_top #(
    parameter int ALARM_SLOTS = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    // configuration write
    input  wire logic             cfg_we,
    input  wire logic [7:0]       cfg_wdata,
    // request channel
    input  wire logic             req_valid,
    output logic                  req_ready,
    input  wire rtcas_pkg::req_t  req,
    // response channel
    output logic                  rsp_valid,
    input  wire logic             rsp_ready,
    output rtcas_pkg::rsp_t       rsp
);

    localparam int SLOT_W = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1;

    // ticks_per_second register
    logic [7:0] tps_reg;

    // time of day and prescaler
    logic [7:0] pre_reg, pre_next;
    logic [5:0] sec_reg, sec_next;
    logic [5:0] min_reg, min_next;
    logic [4:0] hour_reg, hour_next;

    // input register
    logic            req_vld_reg;
    rtcas_pkg::req_t req_reg;

    // result register
    logic            rsp_vld_reg;
    rtcas_pkg::rsp_t rsp_reg;
    rtcas_pkg::rsp_t rsp_next;

    // pipeline control
    logic adv;
    logic proc;

    // slot table interface
    rtcas_pkg::tbl_cmd_t  cmd;
    rtcas_pkg::tbl_stat_t stat;
    logic [SLOT_W-1:0]    free_slot;
    logic [SLOT_W-1:0]    wr_slot;
    logic [SLOT_W-1:0]    rd_slot;

    // request decode helpers
    logic [7:0] pre_inc;
    logic [5:0] sec_inc;
    logic [5:0] min_inc;
    logic [4:0] hour_inc;
    logic       idx_ok;
    logic       alarm_ok;
    logic       time_ok;

    // result register moves when empty or drained
    assign adv       = !rsp_vld_reg || rsp_ready;
    assign req_ready = !req_vld_reg || adv;
    assign proc      = req_vld_reg && adv;

    assign rsp_valid = rsp_vld_reg;
    assign rsp       = rsp_reg;

    assign rd_slot  = SLOT_W'(req_reg.slot_index);
    assign idx_ok   = int'(req_reg.slot_index) < ALARM_SLOTS;
    assign alarm_ok = (req_reg.set_hours < rtcas_pkg::HOUR_LIMIT)
                   && (req_reg.set_minutes < rtcas_pkg::MIN_LIMIT);
    assign time_ok  = alarm_ok && (req_reg.set_seconds < rtcas_pkg::SEC_LIMIT);

    assign pre_inc  = pre_reg + 8'd1;
    assign sec_inc  = sec_reg + 6'd1;
    assign min_inc  = min_reg + 6'd1;
    assign hour_inc = hour_reg + 5'd1;

    rtcas_alarm_table #(
        .ALARM_SLOTS (ALARM_SLOTS)
    ) u_table (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .wr_slot    (wr_slot),
        .rd_slot    (rd_slot),
        .cmp_hour   (hour_next),
        .cmp_minute (min_next),
        .stat       (stat),
        .free_slot  (free_slot)
    );

    // one pass per request: clock update, table command, response fields
    always_comb
    begin
        pre_next  = pre_reg;
        sec_next  = sec_reg;
        min_next  = min_reg;
        hour_next = hour_reg;
        cmd       = '0;
        wr_slot   = free_slot;
        rsp_next  = '0;

        unique case (req_reg.req_type)
            rtcas_pkg::REQ_TICK:
            begin
                // every prescaler count meets a zero rate, so a zero rate advances every tick
                if (pre_inc >= tps_reg)
                begin
                    pre_next = '0;
                    if (sec_inc >= rtcas_pkg::SEC_LIMIT)
                    begin
                        sec_next = '0;
                        if (min_inc >= rtcas_pkg::MIN_LIMIT)
                        begin
                            min_next = '0;
                            if (hour_inc >= rtcas_pkg::HOUR_LIMIT)
                            begin
                                hour_next = '0;
                            end
                            else
                            begin
                                hour_next = hour_inc;
                            end
                        end
                        else
                        begin
                            min_next = min_inc;
                        end
                    end
                    else
                    begin
                        sec_next = sec_inc;
                    end
                end
                else
                begin
                    pre_next = pre_inc;
                end
            end
            rtcas_pkg::REQ_SET:
            begin
                // prescaler kept on a valid set
                if (time_ok)
                begin
                    hour_next = req_reg.set_hours;
                    min_next  = req_reg.set_minutes;
                    sec_next  = req_reg.set_seconds;
                end
                else
                begin
                    rsp_next.status = rtcas_pkg::ST_RANGE;
                end
            end
            rtcas_pkg::REQ_ADD:
            begin
                // full table wins over a bad alarm value
                if (!stat.free_found)
                begin
                    rsp_next.status = rtcas_pkg::ST_FULL;
                end
                else if (!alarm_ok)
                begin
                    rsp_next.status = rtcas_pkg::ST_RANGE;
                end
                else
                begin
                    cmd.wr_en          = proc;
                    cmd.wr_set         = 1'b1;
                    cmd.hour           = req_reg.set_hours;
                    cmd.minute         = req_reg.set_minutes;
                    rsp_next.slot_used = 2'(free_slot);
                end
            end
            rtcas_pkg::REQ_CLEAR:
            begin
                if (!idx_ok)
                begin
                    rsp_next.status = rtcas_pkg::ST_RANGE;
                end
                else
                begin
                    cmd.wr_en          = proc;
                    cmd.wr_set         = 1'b0;
                    wr_slot            = rd_slot;
                    rsp_next.slot_used = req_reg.slot_index;
                end
            end
            rtcas_pkg::REQ_READ:
            begin
                if (!idx_ok)
                begin
                    rsp_next.status = rtcas_pkg::ST_RANGE;
                end
                else
                begin
                    rsp_next.slot_used = req_reg.slot_index;
                    if (stat.rd_valid)
                    begin
                        rsp_next.slot_valid   = 1'b1;
                        rsp_next.slot_hours   = stat.rd_hour;
                        rsp_next.slot_minutes = stat.rd_minute;
                    end
                end
            end
            default:
            begin
                // unknown request code
                rsp_next.status = rtcas_pkg::ST_RANGE;
            end
        endcase

        rsp_next.hours        = hour_next;
        rsp_next.minutes      = min_next;
        rsp_next.seconds      = sec_next;
        rsp_next.alarm_active = stat.match;
    end

    // control and clock state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tps_reg     <= rtcas_pkg::RESET_TPS;
            pre_reg     <= '0;
            sec_reg     <= '0;
            min_reg     <= '0;
            hour_reg    <= '0;
            req_vld_reg <= 1'b0;
            rsp_vld_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                tps_reg <= cfg_wdata;
            end
            if (proc)
            begin
                pre_reg  <= pre_next;
                sec_reg  <= sec_next;
                min_reg  <= min_next;
                hour_reg <= hour_next;
            end
            if (req_ready)
            begin
                req_vld_reg <= req_valid;
            end
            if (adv)
            begin
                rsp_vld_reg <= req_vld_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (req_ready && req_valid)
        begin
            req_reg <= req;
        end
        if (proc)
        begin
            rsp_reg <= rsp_next;
        end
    end

    // reported time always stays a legal time of day
    a_time_legal: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.hours < rtcas_pkg::HOUR_LIMIT)
                   && (rsp.minutes < rtcas_pkg::MIN_LIMIT)
                   && (rsp.seconds < rtcas_pkg::SEC_LIMIT))
        else $error("response time out of range");

    // slot contents only come with an ok status
    a_slot_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.slot_valid) |-> (rsp.status == rtcas_pkg::ST_OK))
        else $error("slot contents with error status");

    // a full table transaction names no slot
    a_full_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status == rtcas_pkg::ST_FULL)
            |-> (rsp.slot_used == 2'd0) && !rsp.slot_valid)
        else $error("full status with slot data");

    // request side only stalls behind a held response
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !req_ready |-> (rsp_valid && !rsp_ready))
        else $error("request stalled without response backpressure");

endmodule

`default_nettype wire
